[src/pcmp_pkg.sv]
// Shared types, mode codes and helpers for the PCM sample width packer.
`timescale 1ns / 1ps
`default_nettype none
package pcmp_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned MaxRes = 3;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ModeW-1:0] mode_t;
  typedef logic [1:0]       cnt_t;

  // Packing modes; codes above 32to24 behave as 16to16.
  typedef enum logic [ModeW-1:0] {
    MODE_16TO8  = 3'd0,
    MODE_16TO16 = 3'd1,
    MODE_32TO8  = 3'd2,
    MODE_32TO16 = 3'd3,
    MODE_32TO24 = 3'd4
  } pack_mode_t;

  localparam mode_t ModeReset = MODE_16TO16;

  // Results released by one input transaction, oldest in slot 0.
  typedef struct packed {
    cnt_t                     cnt;
    logic [MaxRes-1:0]        last;
    logic [MaxRes-1:0][WordW-1:0] word;
  } pcmp_res_t;

  // Group position of the word that closes a group.
  function automatic cnt_t group_last_pos(input mode_t mode);
    cnt_t pos;
    case (mode)
      MODE_16TO8:  pos = 2'd1;
      MODE_32TO8:  pos = 2'd3;
      MODE_32TO16: pos = 2'd1;
      MODE_32TO24: pos = 2'd3;
      default:     pos = 2'd0;
    endcase
    return pos;
  endfunction

endpackage
`default_nettype wire

[src/pcm_sample_fifo_packer.sv]
// Top level of the PCM sample width packer.
// Takes one 32-bit sample word per cycle while in_ready is high and packs groups of 1, 2 or 4
// words into playback FIFO words according to cfg_wr_data (0=16to8, 1=16to16, 2=32to8,
// 3=32to16, 4=32to24; other codes pass through). The packed word of a group appears the
// cycle after its closing word is taken. In 32to24 the closing word releases three words,
// drained one per cycle, while out_ready is high, from a three-entry result queue as the
// next group's first three words are taken, so with out_ready high a steady stream runs at
// one word per cycle in every mode. in_ready only drops when a closing word arrives while
// that queue still holds a word that does not leave in that cycle: two or more words, or
// one word with out_ready low. A mode write restarts the group.
`timescale 1ns / 1ps
`default_nettype none
module pcm_sample_fifo_packer
  import pcmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_sample_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_fifo_word,
  output logic             out_last_of_group
);

  pcmp_res_t res;
  cnt_t      q_count;
  logic      accept;
  logic      load;

  assign in_ready = (res.cnt == 2'd0) || (q_count == 2'd0)
                  || (q_count == 2'd1 && out_ready);
  assign accept   = in_valid && in_ready;
  assign load     = accept && (res.cnt != 2'd0);

  pcmp_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .sample_word (in_sample_word),
    .res         (res)
  );

  pcmp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_fifo_word),
    .out_last  (out_last_of_group),
    .count     (q_count)
  );

endmodule
`default_nettype wire

[src/pcmp_pack.sv]
// Mode register, held words, group position and the packing datapath.
`timescale 1ns / 1ps
`default_nettype none
module pcmp_pack
  import pcmp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_wr_en,
  input  wire mode_t     cfg_wr_data,
  input  wire logic      accept,
  input  wire word_t     sample_word,
  output pcmp_res_t      res
);

  mode_t mode_r;
  cnt_t  pos_r, pos_nxt;
  word_t held0_r, held1_r, held2_r;
  logic  closing;

  assign closing = (pos_r == group_last_pos(mode_r));

  always_comb begin
    if (!accept) begin
      pos_nxt = pos_r;
    end else if (closing) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeReset;
      pos_r  <= '0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
      pos_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
    end
  end

  // Held words never read before written within a group; no reset needed.
  always_ff @(posedge clk) begin
    if (accept && !closing) begin
      case (pos_r)
        2'd0:    held0_r <= sample_word;
        2'd1:    held1_r <= sample_word;
        2'd2:    held2_r <= sample_word;
        default: held2_r <= held2_r;
      endcase
    end
  end

  always_comb begin
    res      = '0;
    res.last = 3'b001;
    res.cnt  = closing ? 2'd1 : 2'd0;
    case (mode_r)
      MODE_16TO8: begin
        res.word[0] = {held0_r[31:24], held0_r[15:8], sample_word[31:24], sample_word[15:8]};
      end
      MODE_32TO8: begin
        res.word[0] = {held0_r[31:24], held1_r[31:24], held2_r[31:24], sample_word[31:24]};
      end
      MODE_32TO16: begin
        res.word[0] = {held0_r[31:16], sample_word[31:16]};
      end
      MODE_32TO24: begin
        res.word[0] = {held0_r[31:8], held1_r[31:24]};
        res.word[1] = {held1_r[23:8], held2_r[31:16]};
        res.word[2] = {held2_r[15:8], sample_word[31:8]};
        res.last    = 3'b100;
        res.cnt     = closing ? 2'd3 : 2'd0;
      end
      default: begin
        res.word[0] = sample_word;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/pcmp_outq.sv]
// Three-entry result queue that releases packed words one per cycle while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module pcmp_outq
  import pcmp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire pcmp_res_t res,
  output logic           out_valid,
  input  wire logic      out_ready,
  output word_t          out_word,
  output logic           out_last,
  output cnt_t           count
);

  cnt_t                         cnt_r, cnt_nxt;
  logic [MaxRes-1:0][WordW-1:0] word_r;
  logic [MaxRes-1:0]            last_r;
  logic                         pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_word  = word_r[0];
  assign out_last  = last_r[0];
  assign count     = cnt_r;

  always_comb begin
    if (load) begin
      cnt_nxt = res.cnt;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= res.word;
      last_r <= res.last;
    end else if (pop) begin
      word_r <= {word_r[MaxRes-1], word_r[MaxRes-1:1]};
      last_r <= {last_r[MaxRes-1], last_r[MaxRes-1:1]};
    end
  end

`ifndef SYNTHESIS
  // A new group only lands when the queue is empty or drains this cycle.
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready))
    else $error("result queue overwritten while holding words");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (cnt_r == $past(res.cnt)))
    else $error("result queue count wrong after load");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("result queue count wrong after pop");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> out_last)
    else $error("final queued word not marked last of group");
`endif

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the PCM sample width packer: random traffic, scoreboard, watchdog.
`timescale 1ns / 1ps
module tb_top;
  import pcmp_pkg::*;

  localparam int unsigned Settle   = 8;     // quiet cycles before a mode write
  localparam int unsigned HoldLen  = 100;   // long receiver hold-off
  localparam int unsigned WdLimit  = 2000;  // cycles with no transaction at all
  localparam int unsigned NumRand  = 500;
  localparam int unsigned DrainCyc = 20;

  typedef struct {
    bit          is_cfg;
    mode_t       mode;
    word_t       word;
    int unsigned gap;
    bit          hold;
  } stim_t;

  typedef struct {
    word_t word;
    logic  last;
  } fifo_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_sample_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_fifo_word;
  logic        out_last_of_group;

  pcm_sample_fifo_packer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_word   (in_sample_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fifo_word    (out_fifo_word),
    .out_last_of_group(out_last_of_group)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stim_t       pend_stim[$];
  fifo_res_t   fifo_expect[$];

  // packer model state
  mode_t       pk_mode;
  word_t       pk_held [3];
  cnt_t        pk_pos;

  int unsigned n_errors = 0;
  int unsigned n_samples = 0;
  int unsigned n_words = 0;
  int unsigned n_mode_wr = 0;
  logic [7:0]  modes_seen = '0;
  int unsigned quiet = 0;
  int unsigned gap_cnt = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_cnt = 0;
  int unsigned run_cnt = 0;
  int unsigned wd_cnt = 0;

  function automatic int unsigned group_len(input mode_t m);
    case (m)
      MODE_16TO8, MODE_32TO16: return 2;
      MODE_32TO8, MODE_32TO24: return 4;
      default:                 return 1;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic word_t rand_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic push_res(input word_t w, input logic last);
    fifo_res_t r;
    r.word = w;
    r.last = last;
    fifo_expect.push_back(r);
  endtask

  // Consume one sample; queue whatever packed words it releases.
  task automatic pack_sample(input word_t w);
    word_t a, b, c;
    if (pk_pos + 1 < group_len(pk_mode)) begin
      pk_held[pk_pos] = w;
      pk_pos = pk_pos + 1'b1;
    end else begin
      pk_pos = '0;
      a = pk_held[0];
      b = pk_held[1];
      c = pk_held[2];
      case (pk_mode)
        MODE_16TO8:  push_res({a[31:24], a[15:8], w[31:24], w[15:8]}, 1'b1);
        MODE_32TO8:  push_res({a[31:24], b[31:24], c[31:24], w[31:24]}, 1'b1);
        MODE_32TO16: push_res({a[31:16], w[31:16]}, 1'b1);
        MODE_32TO24: begin
          push_res({a[31:8], b[31:24]}, 1'b0);
          push_res({b[23:8], c[31:16]}, 1'b0);
          push_res({c[15:8], w[31:8]}, 1'b1);
        end
        default:     push_res(w, 1'b1);
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input word_t got_w, input logic got_l,
                                 input word_t exp_w, input logic exp_l);
    n_errors++;
    $display("[%0t] ERROR %s: got word %08h last %0b, expected word %08h last %0b",
             $time, what, got_w, got_l, exp_w, exp_l);
  endtask

  // Driver: mode writes wait until the packer has gone quiet.
  always @(posedge clk) begin : drv
    logic  v_nxt;
    logic  we_nxt;
    stim_t s;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_wr_en <= 1'b0;
      gap_cnt   <= 0;
    end else begin
      v_nxt  = in_valid;
      we_nxt = 1'b0;
      if (in_valid && in_ready) v_nxt = 1'b0;
      if (!v_nxt && !cfg_wr_en) begin
        if (gap_cnt != 0 && hold_cnt == 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (pend_stim.size() > 0) begin
          if (pend_stim[0].is_cfg) begin
            if (quiet >= Settle && fifo_expect.size() == 0) begin
              s = pend_stim.pop_front();
              we_nxt = 1'b1;
              cfg_wr_data <= s.mode;
            end
          end else begin
            s = pend_stim.pop_front();
            v_nxt = 1'b1;
            in_sample_word <= s.word;
            gap_cnt <= s.gap;
            if (s.hold) hold_seq <= hold_seq + 1;
          end
        end
      end
      in_valid  <= v_nxt;
      cfg_wr_en <= we_nxt;
    end
  end

  // Receiver backpressure, with a long hold-off on request from the driver.
  always @(posedge clk) begin : rcv
    int unsigned r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      run_cnt   <= 0;
      hold_cnt  <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt  <= HoldLen;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= (hold_cnt == 1);
    end else if (run_cnt != 0) begin
      run_cnt <= run_cnt - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready <= 1'b1;
        run_cnt   <= $urandom_range(1, 8);
      end else if (r < 70) begin
        out_ready <= 1'b1;
        run_cnt   <= $urandom_range(20, 60);
      end else if (r < 93) begin
        out_ready <= 1'b0;
        run_cnt   <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        run_cnt   <= $urandom_range(8, 30);
      end
    end
  end

  // Prediction on each accepted transaction, checking on each delivered word.
  always @(posedge clk) begin : mon
    fifo_res_t e;
    if (!rst_n) begin
      pk_mode = MODE_16TO16;
      pk_pos  = '0;
      for (int i = 0; i < 3; i++) pk_held[i] = '0;
      quiet <= 0;
    end else begin
      if (cfg_wr_en) begin
        pk_mode = cfg_wr_data;
        pk_pos  = '0;
        n_mode_wr++;
      end
      if (in_valid && in_ready) begin
        modes_seen[pk_mode] = 1'b1;
        pack_sample(in_sample_word);
        n_samples++;
      end
      if (out_valid && out_ready) begin
        n_words++;
        if (fifo_expect.size() == 0) begin
          report_mismatch("unexpected word", out_fifo_word, out_last_of_group, '0, 1'b0);
        end else begin
          e = fifo_expect.pop_front();
          if (out_fifo_word !== e.word || out_last_of_group !== e.last)
            report_mismatch("fifo word", out_fifo_word, out_last_of_group, e.word, e.last);
        end
      end
      if (in_valid || out_valid || cfg_wr_en) quiet <= 0;
      else if (quiet < 255) quiet <= quiet + 1;
    end
  end

  always @(posedge clk) begin : wdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !rst_n) begin
      wd_cnt <= 0;
    end else if (wd_cnt >= WdLimit) begin
      $display("Watchdog: no transaction for %0d cycles", WdLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      wd_cnt <= wd_cnt + 1;
    end
  end

  task automatic add_word(input word_t w, input int unsigned gap, input bit hold);
    stim_t s;
    s.is_cfg = 1'b0;
    s.mode   = '0;
    s.word   = w;
    s.gap    = gap;
    s.hold   = hold;
    pend_stim.push_back(s);
  endtask

  task automatic add_mode(input mode_t m);
    stim_t s;
    s.is_cfg = 1'b1;
    s.mode   = m;
    s.word   = '0;
    s.gap    = 0;
    s.hold   = 1'b0;
    pend_stim.push_back(s);
  endtask

  initial begin : stim
    int unsigned n_rand;
    int unsigned len;
    int unsigned groups;
    int unsigned nw;
    bit          busy_phase;
    mode_t       m;

    // directed: reset mode pass-through, then each mode with extreme patterns
    add_word('0, pick_gap(), 1'b0);
    add_word('1, pick_gap(), 1'b0);
    add_mode(MODE_16TO8);
    add_word(32'hFFFF_FFFF, 0, 1'b0);
    add_word(32'h0000_0000, 0, 1'b0);
    add_word(32'hA5C3_5A3C, 1, 1'b0);
    add_word(32'h0F0F_F0F0, 0, 1'b0);
    add_mode(MODE_32TO8);
    add_word(32'hFF00_0000, 0, 1'b0);
    add_word(32'h00FF_FFFF, 0, 1'b0);
    add_word(32'h8000_0001, 2, 1'b0);
    add_word(32'h7FFF_FFFE, 0, 1'b0);
    add_mode(MODE_32TO16);
    add_word(32'hFFFF_0000, 0, 1'b0);
    add_word(32'h0000_FFFF, 0, 1'b0);
    add_mode(MODE_32TO24);
    add_word(32'h1122_3344, 0, 1'b0);
    add_word(32'h5566_7788, 0, 1'b0);
    add_word(32'h99AA_BBCC, 0, 1'b0);
    add_word(32'hDDEE_FF00, 0, 1'b0);
    // mode change mid-group drops the two held words
    add_word('1, 0, 1'b0);
    add_word('1, 0, 1'b0);
    add_mode(MODE_32TO16);
    add_word(32'h1234_5678, 0, 1'b0);
    add_word(32'h9ABC_DEF0, 0, 1'b0);
    // undefined codes pass through
    add_mode(3'd5);
    add_word(32'hCAFE_F00D, 0, 1'b0);
    add_mode(3'd6);
    add_word(32'h0BAD_BEEF, 0, 1'b0);
    add_mode(3'd7);
    add_word(32'h8000_0000, 0, 1'b0);

    // back-pressure run: receiver stalls long while 32to24 keeps filling the result queue
    add_mode(MODE_32TO24);
    for (int i = 0; i < 80; i++) add_word(rand_word(), 0, i == 6);
    n_rand = 80;

    while (n_rand < NumRand) begin
      if ($urandom_range(0, 3) == 0) m = MODE_32TO24;
      else m = mode_t'($urandom_range(0, 7));
      add_mode(m);
      len        = group_len(m);
      groups     = $urandom_range(3, 25);
      busy_phase = ($urandom_range(0, 3) == 0);
      for (int g = 0; g < groups; g++) begin
        // mostly whole groups, now and then a truncated one
        nw = len;
        if (len > 1 && $urandom_range(0, 9) == 0) nw = $urandom_range(1, len - 1);
        for (int k = 0; k < nw; k++) begin
          add_word(rand_word(), busy_phase ? 0 : pick_gap(), $urandom_range(0, 199) == 0);
          n_rand++;
        end
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pend_stim.size() != 0 || in_valid || cfg_wr_en || fifo_expect.size() != 0);
    repeat (DrainCyc) @(negedge clk);

    while (fifo_expect.size() != 0) begin
      report_mismatch("missing word", '0, 1'b0, fifo_expect[0].word, fifo_expect[0].last);
      void'(fifo_expect.pop_front());
    end

    $display("Run covered %0d samples, %0d FIFO words, %0d mode writes (modes used: %08b)",
             n_samples, n_words, n_mode_wr, modes_seen);
    $display("Errors: %0d", n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
